// ===== rtl/core/fpoc_pkg.sv =====
`timescale 1ns / 1ps

package fpoc_pkg;

  localparam int PIX_W      = 8;
  localparam int IDX_W      = 14;
  localparam int SLOT_DEPTH = 16384;
  localparam int SUM_W      = 22;
  localparam int CNT_W      = 15;

  // action codes of an input item
  localparam logic [1:0] ACT_CORRECT = 2'd0;
  localparam logic [1:0] ACT_LOAD    = 2'd1;
  localparam logic [1:0] ACT_CALIB   = 2'd2;
  localparam logic [1:0] ACT_NONE    = 2'd3;

  typedef enum logic [1:0] {
    OP_CORRECT,
    OP_LOAD,
    OP_CALIB
  } op_t;

  typedef struct packed {
    logic [1:0]              action;
    logic                    camera;
    logic [IDX_W-1:0]        pixel_index;
    logic [PIX_W-1:0]        pixel_value;
    logic signed [PIX_W-1:0] mask_value;
    logic                    frame_last;
  } in_item_t;

  typedef struct packed {
    logic [PIX_W-1:0] corrected_pixel;
    logic             out_camera;
    logic [IDX_W-1:0] out_index;
  } out_item_t;

  // classified command passed from front to back
  typedef struct packed {
    op_t              op;
    logic             cam;
    logic             pass;
    logic [IDX_W-1:0] idx;
    logic [PIX_W-1:0] pix;
    logic [PIX_W-1:0] mval;
    logic             last;
  } cmd_t;

endpackage

// ===== rtl/core/fpoc_stream_if.sv =====
`timescale 1ns / 1ps

interface fpoc_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// ===== rtl/core/fixed_pattern_offset_correction.sv =====
`timescale 1ns / 1ps

// channel   dir  payload     notes
// pixels    in   in_item_t   action, camera, pixel_index, pixel_value, mask_value, frame_last
// results   out  out_item_t  one item per correct or calibrate action, none otherwise
//
// steady rate is one item per cycle while results.ready holds and no calibration walk runs;
// a pixel from the front queue has its mask read, then is clamped into the output register
// the last pixel of a calibration frame holds the back end through the reciprocal-multiply
// average and then the mask rewrite walk
// rst clears control state, sums and counts; mask and capture memories start undefined
// a stalled result holds the result stage, then the two-entry front queue, then pixels.ready

module fixed_pattern_offset_correction
  import fpoc_pkg::*;
#(
  parameter int FRAME_PIXELS = 16384,
  parameter int CAMERAS      = 2
) (
  input  logic          clk,
  input  logic          rst,
  fpoc_stream_if.sink   pixels,
  fpoc_stream_if.source results
);

  // classified items waiting for the back end
  logic q_valid;
  logic q_ready;
  cmd_t cmd;

  // front: queues items while it has room, drops unused codes and loads to a missing camera
  fpoc_front #(
    .CAMERAS(CAMERAS)
  ) u_front (
    .clk    (clk),
    .rst    (rst),
    .pixels (pixels),
    .q_valid(q_valid),
    .q_ready(q_ready),
    .cmd    (cmd)
  );

  // back: mask loads, mask lookup and clamp, capture, average and mask rewrite
  fpoc_back #(
    .FRAME_PIXELS(FRAME_PIXELS),
    .CAMERAS     (CAMERAS)
  ) u_back (
    .clk    (clk),
    .rst    (rst),
    .q_valid(q_valid),
    .q_ready(q_ready),
    .cmd    (cmd),
    .results(results)
  );

endmodule

// ===== rtl/core/fpoc_div.sv =====
`timescale 1ns / 1ps

module fpoc_div
  import fpoc_pkg::*;
#(
  parameter int FRAME_PIXELS = 16384
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [SUM_W-1:0] dividend,
  output logic             done,
  output logic [PIX_W-1:0] quotient
);

  // reciprocal multiplication, exact for every SUM_W-bit dividend
  localparam int     DIV_SHIFT = SUM_W + $clog2(FRAME_PIXELS);
  localparam int     RECIP_W   = SUM_W + 1;
  localparam int     PROD_W    = SUM_W + RECIP_W;
  localparam longint RECIP_L   =
    ((longint'(1) << DIV_SHIFT) + longint'(FRAME_PIXELS) - 1) / longint'(FRAME_PIXELS);
  localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_L);

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= start;
    end
  end

  // only the low byte of the average is needed downstream
  always_ff @(posedge clk) begin
    if (start) begin
      quotient <= PIX_W'((PROD_W'(dividend) * PROD_W'(RECIP)) >> DIV_SHIFT);
    end
  end

endmodule

// ===== rtl/core/fpoc_front.sv =====
`timescale 1ns / 1ps

module fpoc_front
  import fpoc_pkg::*;
#(
  parameter int CAMERAS = 2
) (
  input  logic          clk,
  input  logic          rst,
  fpoc_stream_if.sink   pixels,
  output logic          q_valid,
  input  logic          q_ready,
  output cmd_t          cmd
);

  cmd_t       slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       accept;
  logic       push;
  logic       pop;
  logic       cam_bad;
  cmd_t       cmd_in;

  assign pixels.ready = !rst && (count != 2'd2);
  assign accept       = pixels.valid && pixels.ready;
  assign q_valid      = (count != 2'd0);
  assign cmd          = slots[rd_ptr];
  assign pop          = q_valid && q_ready;

  // classify: unused code and loads to a missing camera are dropped here
  always_comb begin
    cam_bad       = (32'(pixels.payload.camera) >= CAMERAS);
    cmd_in.cam    = pixels.payload.camera;
    cmd_in.pass   = cam_bad;
    cmd_in.idx    = pixels.payload.pixel_index;
    cmd_in.pix    = pixels.payload.pixel_value;
    cmd_in.mval   = pixels.payload.mask_value;
    cmd_in.last   = pixels.payload.frame_last;
    cmd_in.op     = OP_CORRECT;
    push          = accept;
    unique case (pixels.payload.action)
      ACT_CORRECT: cmd_in.op = OP_CORRECT;
      ACT_LOAD: begin
        cmd_in.op = OP_LOAD;
        push      = accept && !cam_bad;
      end
      ACT_CALIB:   cmd_in.op = OP_CALIB;
      ACT_NONE:    push = 1'b0;
      default:     push = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop)  rd_ptr <= !rd_ptr;
      unique case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= cmd_in;
  end

endmodule

// ===== rtl/core/fpoc_back.sv =====
`timescale 1ns / 1ps

module fpoc_back
  import fpoc_pkg::*;
#(
  parameter int FRAME_PIXELS = 16384,
  parameter int CAMERAS      = 2
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          q_valid,
  output logic          q_ready,
  input  cmd_t          cmd,
  fpoc_stream_if.source results
);

  localparam int MASK_CAMS  = (CAMERAS < 2) ? 1 : 2;
  localparam int MASK_DEPTH = MASK_CAMS * SLOT_DEPTH;
  localparam int MADDR_W    = $clog2(MASK_DEPTH);

  typedef enum logic [1:0] {
    ST_RUN,
    ST_DIV,
    ST_WALK
  } state_t;

  state_t state;

  logic [PIX_W-1:0] mask_mem [MASK_DEPTH];
  logic [PIX_W-1:0] cap_mem  [SLOT_DEPTH];

  logic [SUM_W-1:0] raw_sum;
  logic [SUM_W-1:0] raw_sum_next;
  logic [CNT_W-1:0] capture_count;
  logic             cap_room;

  // issue stage
  logic             issue;
  logic             issue_pix;
  logic             issue_load;
  logic             issue_cap;
  logic [PIX_W-1:0] mask_rd;

  // result stage
  logic             b_valid;
  logic             b_cam;
  logic             b_pass;
  logic [IDX_W-1:0] b_idx;
  logic [PIX_W-1:0] b_pix;
  logic             b_moves;
  logic             b_room;
  logic signed [PIX_W+1:0] sum;
  logic [PIX_W-1:0] clamped;
  out_item_t        o_item;
  logic             o_valid;

  // writeback walk
  logic             walk_cam;
  logic             walk_pass;
  logic [CNT_W-1:0] walk_k;
  logic             w_valid;
  logic [IDX_W-1:0] w_idx;
  logic [PIX_W-1:0] cap_rd;
  logic [PIX_W-1:0] avg;

  // mask write port
  logic               mw_en;
  logic [MADDR_W-1:0] mw_addr;
  logic [PIX_W-1:0]   mw_data;

  logic             div_start;
  logic             div_done;
  logic [PIX_W-1:0] div_quot;

  assign results.valid   = o_valid;
  assign results.payload = o_item;

  assign b_moves    = b_valid && (!o_valid || results.ready);
  assign b_room     = !b_valid || b_moves;
  assign q_ready    = (state == ST_RUN) && ((cmd.op == OP_LOAD) || b_room);
  assign issue      = q_valid && q_ready;
  assign issue_load = issue && (cmd.op == OP_LOAD);
  assign issue_pix  = issue && (cmd.op != OP_LOAD);
  assign cap_room   = (capture_count < CNT_W'(SLOT_DEPTH));
  assign issue_cap  = issue && (cmd.op == OP_CALIB) && cap_room;
  assign raw_sum_next = raw_sum + SUM_W'(cmd.pix);
  assign div_start  = issue && (cmd.op == OP_CALIB) && cmd.last;

  fpoc_div #(
    .FRAME_PIXELS(FRAME_PIXELS)
  ) u_div (
    .clk     (clk),
    .rst     (rst),
    .start   (div_start),
    .dividend(issue_cap ? raw_sum_next : raw_sum),
    .done    (div_done),
    .quotient(div_quot)
  );

  // pixel plus signed offset, clamped to a byte
  always_comb begin
    sum = $signed({2'b00, b_pix}) + $signed({{2{mask_rd[PIX_W-1]}}, mask_rd});
    if (sum[PIX_W+1])    clamped = '0;
    else if (sum[PIX_W]) clamped = '1;
    else                 clamped = sum[PIX_W-1:0];
  end

  // mask write: loads in normal running, writeback during the walk
  always_comb begin
    if (w_valid) begin
      mw_en   = !walk_pass;
      mw_addr = MADDR_W'({walk_cam, w_idx});
      mw_data = avg - cap_rd;
    end else begin
      mw_en   = issue_load;
      mw_addr = MADDR_W'({cmd.cam, cmd.idx});
      mw_data = cmd.mval;
    end
  end

  always_ff @(posedge clk) begin
    if (mw_en) mask_mem[mw_addr] <= mw_data;
    if (issue_pix) mask_rd <= mask_mem[MADDR_W'({cmd.cam, cmd.idx})];
  end

  always_ff @(posedge clk) begin
    if (issue_cap) cap_mem[capture_count[IDX_W-1:0]] <= cmd.pix;
    if (state == ST_WALK && walk_k < capture_count) begin
      cap_rd <= cap_mem[walk_k[IDX_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (issue_pix) begin
      b_cam  <= cmd.cam;
      b_pass <= cmd.pass;
      b_idx  <= cmd.idx;
      b_pix  <= cmd.pix;
    end
    if (b_moves) begin
      o_item.corrected_pixel <= b_pass ? b_pix : clamped;
      o_item.out_camera      <= b_cam;
      o_item.out_index       <= b_idx;
    end
    if (div_start) begin
      walk_cam  <= cmd.cam;
      walk_pass <= cmd.pass;
    end
    if (div_done) avg <= div_quot;
    if (state == ST_WALK) w_idx <= walk_k[IDX_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_RUN;
      b_valid       <= 1'b0;
      o_valid       <= 1'b0;
      raw_sum       <= '0;
      capture_count <= '0;
      walk_k        <= '0;
      w_valid       <= 1'b0;
    end else begin
      if (issue_pix)    b_valid <= 1'b1;
      else if (b_moves) b_valid <= 1'b0;

      if (b_moves)            o_valid <= 1'b1;
      else if (results.ready) o_valid <= 1'b0;

      unique case (state)
        ST_RUN: begin
          if (issue_cap) begin
            raw_sum       <= raw_sum_next;
            capture_count <= capture_count + 1'b1;
          end
          if (div_start) state <= ST_DIV;
        end
        ST_DIV: begin
          walk_k <= '0;
          if (div_done) state <= ST_WALK;
        end
        ST_WALK: begin
          if (walk_k < capture_count) begin
            w_valid <= 1'b1;
            walk_k  <= walk_k + 1'b1;
          end else begin
            w_valid       <= 1'b0;
            raw_sum       <= '0;
            capture_count <= '0;
            state         <= ST_RUN;
          end
        end
        default: state <= ST_RUN;
      endcase
    end
  end

endmodule
